[rtl/longest_window_sum_at_most_defines.svh]
// assertion macros for the longest window sum block
`ifndef LONGEST_WINDOW_SUM_AT_MOST_DEFINES_SVH
`define LONGEST_WINDOW_SUM_AT_MOST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LWSAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LWSAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lwsam_pkg.sv]
// shared types and constants for the longest window sum block
`default_nettype none

package lwsam_pkg;

  localparam int VALUE_W     = 16;
  localparam int THR_W       = 32;
  localparam int BEST_W      = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - BEST_W - 1;

  localparam logic [BEST_W-1:0] BEST_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FULL,
    S_PUSH,
    S_CHECK,
    S_POP,
    S_EMIT
  } lwsam_state_t;

endpackage

`default_nettype wire

[rtl/lwsam_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module lwsam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/longest_window_sum_at_most.sv]
// longest run of a value stream whose sum stays within a threshold
//
// channels: in_* carries one value per transaction, in_tlast closes a
// sequence; out_* carries one result per sequence (best length, overflow);
// cfg_* writes the 32-bit threshold, always ready; the user must write it
// only while idle, the block does not enforce this. values go into a
// DEPTH-entry ring buffer; while the window sum exceeds the threshold the
// oldest value is read back and subtracted, through a single shared
// add/subtract unit and the ram read port. each value is dropped at most
// once; when the buffer is full the oldest value is dropped first.
// in_tready is low while an item is being worked on.
// the result of a tlast item is registered once the window sum is within
// the threshold; the next item can be taken while that result waits.
// if the receiver stalls and a new tlast item finishes, the block holds in
// an emit state until the output register frees up.
// reset (synchronous, rst_n low) clears the threshold to 0 and all window
// state; ram contents are not cleared, only entries inside the window are
// read. after a tlast item the window state clears for the next sequence.
`default_nettype none

module longest_window_sum_at_most
  import lwsam_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] value
  input  wire logic                   in_tlast,   // last value of the sequence
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [10:0] best_length, [11] overflow
  // threshold write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [THR_W-1:0]       cfg_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = VALUE_W + CW;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int BW    = (CW > BEST_W) ? CW : BEST_W;

  // saturate the tracked best length to the result field
  function automatic logic [BEST_W-1:0] sat_best(input logic [CW-1:0] b);
    logic [BW-1:0] bext;
    bext = BW'(b);
    return (bext > BW'(BEST_MAX)) ? BEST_MAX : bext[BEST_W-1:0];
  endfunction

  lwsam_state_t     state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]    best_r, best_nxt;
  logic             ovf_r, ovf_nxt;
  logic [THR_W-1:0] thr_r;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // shared add/subtract unit on the window sum
  logic [VALUE_W-1:0] alu_b;
  logic               alu_sub;
  logic [SUM_W-1:0]   alu_res;

  // ring buffer ports
  logic               ram_we;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [VALUE_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic is_full;
  logic over_thr;
  logic [CW-1:0] best_upd;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_full  = (cnt_r == CW'(DEPTH));
  assign over_thr = (cnt_r != '0) && (CMP_W'(sum_r) > CMP_W'(thr_r));
  assign best_upd = (cnt_r > best_r) ? cnt_r : best_r;

  assign alu_res = alu_sub ? (sum_r - SUM_W'(alu_b)) : (sum_r + SUM_W'(alu_b));

  lwsam_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tail_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    alu_b         = ram_rdata;
    alu_sub       = 1'b1;
    ram_we        = 1'b0;
    ram_wdata     = val_r;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt  = in_tdata[VALUE_W-1:0];
          last_nxt = in_tlast;
          if (is_full) begin
            // oldest entry sits where the new value goes: read it first
            ram_re    = 1'b1;
            state_nxt = S_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = in_tdata[VALUE_W-1:0];
            alu_b     = in_tdata[VALUE_W-1:0];
            alu_sub   = 1'b0;
            sum_nxt   = alu_res;
            cnt_nxt   = cnt_r + 1'b1;
            head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_FULL: begin
        sum_nxt   = alu_res;
        cnt_nxt   = cnt_r - 1'b1;
        tail_nxt  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
        ovf_nxt   = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        ram_we    = 1'b1;
        alu_b     = val_r;
        alu_sub   = 1'b0;
        sum_nxt   = alu_res;
        cnt_nxt   = cnt_r + 1'b1;
        head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (over_thr) begin
          ram_re    = 1'b1;
          state_nxt = S_POP;
        end else begin
          best_nxt = best_upd;
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {{OUT_PAD_W{1'b0}}, ovf_r, sat_best(best_upd)};
            head_nxt      = '0;
            tail_nxt      = '0;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            best_nxt      = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_POP: begin
        sum_nxt   = alu_res;
        cnt_nxt   = cnt_r - 1'b1;
        tail_nxt  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
        state_nxt = S_CHECK;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, ovf_r, sat_best(best_r)};
          head_nxt      = '0;
          tail_nxt      = '0;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          best_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[rtl/lwsam_chk.sv]
// port-level checker for the longest window sum block, with its bind
`default_nettype none

`include "longest_window_sum_at_most_defines.svh"

module lwsam_chk
  import lwsam_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // best length when the buffer was ever full
  localparam logic [BEST_W-1:0] FULL_LEN =
    (DEPTH > int'(BEST_MAX)) ? BEST_MAX : BEST_W'(DEPTH);

  // a stalled result transaction keeps its payload
  `LWSAM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")

  // no two items are accepted back to back
  `LWSAM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready,
    !in_tready, "ready right after an input transaction")

  // a new result only comes out of a busy cycle
  `LWSAM_ASSERT_NOW(a_result_from_work, $rose(out_tvalid),
    $past(!in_tready), "result appeared while idle")

  // overflow means the window once filled the buffer
  `LWSAM_ASSERT_NOW(a_ovf_len, out_tvalid && out_tdata[BEST_W],
    out_tdata[BEST_W-1:0] == FULL_LEN, "overflow with short best length")

  // best length never exceeds the buffer depth
  `LWSAM_ASSERT_NOW(a_len_bound, out_tvalid,
    out_tdata[BEST_W-1:0] <= FULL_LEN, "best length beyond depth")

endmodule

bind longest_window_sum_at_most lwsam_chk #(
  .DEPTH (DEPTH)
) u_lwsam_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
